>>> rtl/mtdr_pkg.sv
package mtdr_pkg;

    // Field widths of the input and result words.
    localparam int GREEN_W = 24;
    localparam int TRIG_W  = 16;
    localparam int SCALE_W = 24;
    localparam int OUT_W   = 32;
    localparam int DATA_W  = 32;
    localparam int ADDR_W  = 5;

    // Datapath widths. A row value is held exactly in units of 1/(3*2^15).
    localparam int PROD_W  = TRIG_W + GREEN_W;      // trig times Green's sample
    localparam int N_W     = 42;                    // signed row value
    localparam int MAG_W   = N_W - 1;               // its magnitude
    localparam int LO_W    = 21;                    // low slice of the magnitude
    localparam int HI_W    = MAG_W - LO_W;          // high slice of the magnitude
    localparam int PLO_W   = LO_W + SCALE_W;
    localparam int PHI_W   = HI_W + SCALE_W;
    localparam int ACC_W   = MAG_W + SCALE_W + 1;
    localparam int RND_SH  = 31;
    localparam int SH_W    = ACC_W - RND_SH;        // value over 2^31, still times 3
    localparam int X_W     = 33;                    // dividend once saturation is split off
    localparam int XL_W    = 17;
    localparam int XH_W    = X_W - XL_W;
    localparam int RH_W    = 2;
    localparam int Y_W     = RH_W + XL_W;
    localparam int PH_W    = XH_W + XL_W;           // high quotient product
    localparam int PL_W    = 2 * Y_W;               // low quotient product
    localparam int RL_SH   = 20;

    // Rounding and division by three.
    localparam logic [ACC_W-1:0] ROUND_BIAS = ACC_W'(64'd3 << 30);
    localparam logic [SH_W-1:0]  SAT_LIMIT  = SH_W'(64'd3 << 31);
    localparam logic [XL_W-1:0]  RECIP_HI   = XL_W'(43691);   // ceil(2^17 / 3)
    localparam logic [Y_W-1:0]   RECIP_LO   = Y_W'(349526);   // ceil(2^20 / 3)

    // Pipeline depth from accepted word to result strobe.
    localparam int LATENCY   = 7;
    localparam int NUM_LANES = 7;

    // Lane order of the result word.
    localparam int LANE_XX  = 0;
    localparam int LANE_YY  = 1;
    localparam int LANE_XY  = 2;
    localparam int LANE_XZ  = 3;
    localparam int LANE_YZ  = 4;
    localparam int LANE_ZZ  = 5;
    localparam int LANE_OBS = 6;

    // Register map, indexed by paddr[4:2].
    localparam logic [2:0] REG_MODE  = 3'd0;
    localparam logic [2:0] REG_COS1  = 3'd1;
    localparam logic [2:0] REG_SIN1  = 3'd2;
    localparam logic [2:0] REG_COS2  = 3'd3;
    localparam logic [2:0] REG_SIN2  = 3'd4;
    localparam logic [2:0] REG_SCALE = 3'd5;

    // Register reset values.
    localparam logic [1:0]                RST_MODE  = 2'd1;
    localparam logic signed [TRIG_W-1:0]  RST_COS   = 16'sd16384;
    localparam logic signed [TRIG_W-1:0]  RST_SIN   = 16'sd0;
    localparam logic [SCALE_W-1:0]        RST_SCALE = 24'd65536;

    typedef enum logic [1:0] {
        MODE_EXPLOSION  = 2'd0,
        MODE_DEVIATORIC = 2'd1,
        MODE_FULL       = 2'd2
    } t_mode;

    typedef enum logic [1:0] {
        COMP_TRANSVERSE = 2'd0,
        COMP_RADIAL     = 2'd1,
        COMP_VERTICAL   = 2'd2
    } t_comp;

    typedef logic signed [N_W-1:0] t_n;

    typedef struct packed {
        logic [1:0]                 component;
        logic signed [GREEN_W-1:0]  green_strike_slip;
        logic signed [GREEN_W-1:0]  green_dip_slip;
        logic signed [GREEN_W-1:0]  green_dip45;
        logic signed [GREEN_W-1:0]  green_explosion;
        logic signed [GREEN_W-1:0]  observed_sample;
    } t_in_word;

    typedef struct packed {
        logic signed [OUT_W-1:0] coef_xx;
        logic signed [OUT_W-1:0] coef_yy;
        logic signed [OUT_W-1:0] coef_xy;
        logic signed [OUT_W-1:0] coef_xz;
        logic signed [OUT_W-1:0] coef_yz;
        logic signed [OUT_W-1:0] coef_zz;
        logic signed [OUT_W-1:0] scaled_observation;
    } t_out_word;

endpackage

>>> rtl/moment_tensor_design_row_unit.sv
// Design-matrix row unit for moment-tensor inversion.
// Input channel: a word (component tag, four Green's function samples and the
// observed sample) is taken at each rising edge where start is high and busy
// is low. busy stays low, so a new word may be offered in every cycle.
// Result channel: o_done is high for one cycle while o_word holds the six
// moment-tensor coefficients and the scaled observation of one row.
// Throughput is one word per cycle. The depth from the accepting edge to the
// edge that takes the result is set by the trig multiply, the row sum, the
// sign and magnitude step, the split 41x24 scale multiply, the rounding add
// and the two digits of the division by three, one register stage each.
// Configuration: an APB-style port holds the inversion mode, the four azimuth
// trig terms and the station scale at byte addresses 0 to 20. pready is
// always high. The user must write registers only while no word is in flight; the block itself does not enforce this.
// Reset clears the valid pipeline and loads the register defaults; words in
// flight are dropped. The receiver cannot stall, so nothing is held back.
module moment_tensor_design_row_unit import mtdr_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    output logic               busy,
    input  t_in_word           i_word,
    output logic               o_done,
    output t_out_word          o_word,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [ADDR_W-1:0]  paddr,
    input  logic [DATA_W-1:0]  pwdata,
    output logic [DATA_W-1:0]  prdata,
    output logic               pready
);

    // Configuration registers.
    logic [1:0]                r_mode;
    logic signed [TRIG_W-1:0]  r_cos1;
    logic signed [TRIG_W-1:0]  r_sin1;
    logic signed [TRIG_W-1:0]  r_cos2;
    logic signed [TRIG_W-1:0]  r_sin2;
    logic [SCALE_W-1:0]        r_scale;

    logic                      w_accept;
    logic                      w_cfg_wr;
    logic [2:0]                w_index;

    // Valid pipeline.
    logic [LATENCY-1:0]        r_valid;
    logic [LATENCY-1:0]        n_valid;

    // Stage 1: trig products and pass-through samples.
    logic signed [PROD_W-1:0]  r_c2ss;
    logic signed [PROD_W-1:0]  r_s2ss;
    logic signed [PROD_W-1:0]  r_c1ds;
    logic signed [PROD_W-1:0]  r_s1ds;
    logic signed [GREEN_W-1:0] r_dd;
    logic signed [GREEN_W-1:0] r_ep;
    logic signed [GREEN_W-1:0] r_ob;
    logic [1:0]                r_comp;

    // Stage 2: exact row values.
    t_n                        r_n [NUM_LANES];
    t_n                        n_n [NUM_LANES];

    logic signed [OUT_W-1:0]   w_value [NUM_LANES];

    assign pready   = 1'b1;
    assign busy     = 1'b0;
    assign w_accept = start && !busy;
    assign w_cfg_wr = psel && penable && pwrite && pready;
    assign w_index  = paddr[ADDR_W-1:2];

    // Register writes; indexes past the map are dropped.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode  <= RST_MODE;
            r_cos1  <= RST_COS;
            r_sin1  <= RST_SIN;
            r_cos2  <= RST_COS;
            r_sin2  <= RST_SIN;
            r_scale <= RST_SCALE;
        end else if (w_cfg_wr) begin
            unique case (w_index)
                REG_MODE:  r_mode  <= pwdata[1:0];
                REG_COS1:  r_cos1  <= pwdata[TRIG_W-1:0];
                REG_SIN1:  r_sin1  <= pwdata[TRIG_W-1:0];
                REG_COS2:  r_cos2  <= pwdata[TRIG_W-1:0];
                REG_SIN2:  r_sin2  <= pwdata[TRIG_W-1:0];
                REG_SCALE: r_scale <= pwdata[SCALE_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // Register read-back; trig terms come back sign-extended.
    always_comb begin
        unique case (w_index)
            REG_MODE:  prdata = DATA_W'(r_mode);
            REG_COS1:  prdata = DATA_W'(r_cos1);
            REG_SIN1:  prdata = DATA_W'(r_sin1);
            REG_COS2:  prdata = DATA_W'(r_cos2);
            REG_SIN2:  prdata = DATA_W'(r_sin2);
            REG_SCALE: prdata = DATA_W'(r_scale);
            default:   prdata = '0;
        endcase
    end

    // The valid bit of each word moves one stage per cycle.
    assign n_valid = {r_valid[LATENCY-2:0], w_accept};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else begin
            r_valid <= n_valid;
        end
    end

    // Stage 1: the four azimuth products.
    always_ff @(posedge i_clk) begin
        r_c2ss <= r_cos2 * i_word.green_strike_slip;
        r_s2ss <= r_sin2 * i_word.green_strike_slip;
        r_c1ds <= r_cos1 * i_word.green_dip_slip;
        r_s1ds <= r_sin1 * i_word.green_dip_slip;
        r_dd   <= i_word.green_dip45;
        r_ep   <= i_word.green_explosion;
        r_ob   <= i_word.observed_sample;
        r_comp <= i_word.component;
    end

    // Stage 2: row values in units of 1/(3*2^15), picked by component and mode.
    always_comb begin
        t_n c2ss3;
        t_n s2ss3;
        t_n c2ss6;
        t_n s2ss6;
        t_n c1ds6;
        t_n s1ds6;
        t_n dd14;
        t_n dd15;
        t_n ep15;
        t_n ob15;
        c2ss3 = (t_n'(r_c2ss) <<< 1) + t_n'(r_c2ss);
        s2ss3 = (t_n'(r_s2ss) <<< 1) + t_n'(r_s2ss);
        c2ss6 = c2ss3 <<< 1;
        s2ss6 = s2ss3 <<< 1;
        c1ds6 = ((t_n'(r_c1ds) <<< 1) + t_n'(r_c1ds)) <<< 1;
        s1ds6 = ((t_n'(r_s1ds) <<< 1) + t_n'(r_s1ds)) <<< 1;
        dd14  = t_n'(r_dd) <<< 14;
        dd15  = t_n'(r_dd) <<< 15;
        ep15  = t_n'(r_ep) <<< 15;
        ob15  = t_n'(r_ob) <<< 15;
        for (int i = 0; i < NUM_LANES; i++) begin
            n_n[i] = '0;
        end
        n_n[LANE_OBS] = (ob15 <<< 1) + ob15;
        unique case (r_comp)
            COMP_TRANSVERSE: begin
                if (r_mode != MODE_EXPLOSION) begin
                    n_n[LANE_XX] = s2ss3;
                    n_n[LANE_YY] = -s2ss3;
                    n_n[LANE_XY] = -c2ss6;
                    n_n[LANE_XZ] = s1ds6;
                    n_n[LANE_YZ] = -c1ds6;
                end
            end
            COMP_RADIAL, COMP_VERTICAL: begin
                unique case (r_mode)
                    MODE_EXPLOSION: begin
                        n_n[LANE_XX] = ep15;
                        n_n[LANE_YY] = ep15;
                        n_n[LANE_ZZ] = ep15;
                    end
                    MODE_DEVIATORIC: begin
                        n_n[LANE_XX] = c2ss3 - ((dd14 <<< 1) + dd14);
                        n_n[LANE_YY] = -c2ss3 - ((dd14 <<< 1) + dd14);
                        n_n[LANE_XY] = s2ss6;
                        n_n[LANE_XZ] = c1ds6;
                        n_n[LANE_YZ] = s1ds6;
                    end
                    default: begin
                        // Full tensor; the unused mode code is taken as full.
                        n_n[LANE_XX] = c2ss3 - dd14 + ep15;
                        n_n[LANE_YY] = -c2ss3 - dd14 + ep15;
                        n_n[LANE_XY] = s2ss6;
                        n_n[LANE_XZ] = c1ds6;
                        n_n[LANE_YZ] = s1ds6;
                        n_n[LANE_ZZ] = dd15 + ep15;
                    end
                endcase
            end
            default: begin
                // Unknown component: coefficients stay zero.
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        for (int i = 0; i < NUM_LANES; i++) begin
            r_n[i] <= n_n[i];
        end
    end

    // Stages 3 to 7: scale, round, divide by three and saturate each value.
    for (genvar g = 0; g < NUM_LANES; g++) begin : g_lane
        mtdr_scale_lane u_lane (
            .i_clk   (i_clk),
            .i_n     (r_n[g]),
            .i_scale (r_scale),
            .o_value (w_value[g])
        );
    end

    assign o_done                    = r_valid[LATENCY-1];
    assign o_word.coef_xx            = w_value[LANE_XX];
    assign o_word.coef_yy            = w_value[LANE_YY];
    assign o_word.coef_xy            = w_value[LANE_XY];
    assign o_word.coef_xz            = w_value[LANE_XZ];
    assign o_word.coef_yz            = w_value[LANE_YZ];
    assign o_word.coef_zz            = w_value[LANE_ZZ];
    assign o_word.scaled_observation = w_value[LANE_OBS];

`ifndef SYNTH
    // Every accepted word shows up exactly once as a result strobe.
    a_done_follows_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |-> ##LATENCY o_done)
        else $error("accepted word produced no result strobe");

    a_no_spurious_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_accept |-> ##LATENCY !o_done)
        else $error("result strobe without an accepted word");

    // An unknown component tag yields an all-zero coefficient set.
    a_unknown_comp_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && (&i_word.component)) |-> ##LATENCY
        (o_word.coef_xx == 0 && o_word.coef_yy == 0 && o_word.coef_xy == 0 &&
         o_word.coef_xz == 0 && o_word.coef_yz == 0 && o_word.coef_zz == 0))
        else $error("unknown component gave nonzero coefficients");
`endif

endmodule

>>> rtl/mtdr_scale_lane.sv
module mtdr_scale_lane import mtdr_pkg::*; (
    input  logic                     i_clk,
    input  t_n                       i_n,
    input  logic [SCALE_W-1:0]       i_scale,
    output logic signed [OUT_W-1:0]  o_value
);

    // Stage 3: sign and magnitude.
    logic               r_neg3;
    logic [MAG_W-1:0]   r_mag;
    // Stage 4: partial products of magnitude and scale.
    logic               r_neg4;
    logic [PLO_W-1:0]   r_plo;
    logic [PHI_W-1:0]   r_phi;
    // Stage 5: rounded value over 2^31.
    logic               r_neg5;
    logic [SH_W-1:0]    r_sh;
    // Stage 6: first digit of the division by three.
    logic               r_neg6;
    logic               r_sat;
    logic [XH_W-1:0]    r_qh;
    logic [RH_W-1:0]    r_rh;
    logic [XL_W-1:0]    r_xl;
    // Stage 7: final value.
    logic signed [OUT_W-1:0] r_value;

    logic [MAG_W-1:0]        n_mag;
    logic [PLO_W-1:0]        n_plo;
    logic [PHI_W-1:0]        n_phi;
    logic [ACC_W-1:0]        n_acc;
    logic [XH_W-1:0]         n_xh;
    logic [PH_W-1:0]         n_prod_h;
    logic [XH_W-1:0]         n_qh;
    logic [XH_W-1:0]         n_rem;
    logic [Y_W-1:0]          n_y;
    logic [PL_W-1:0]         n_prod_l;
    logic [X_W-1:0]          n_q;
    logic signed [OUT_W-1:0] n_value;

    // Magnitude of the row value; it never reaches the most negative code.
    assign n_mag = i_n[N_W-1] ? MAG_W'(-i_n) : MAG_W'(i_n);

    // Magnitude times scale in two slices.
    assign n_plo = PLO_W'(r_mag[LO_W-1:0]) * PLO_W'(i_scale);
    assign n_phi = PHI_W'(r_mag[MAG_W-1:LO_W]) * PHI_W'(i_scale);

    // Join the slices, add half of 3*2^31 and drop the low bits.
    assign n_acc = {r_phi, LO_W'(0)} + ACC_W'(r_plo) + ROUND_BIAS;

    // High digit of the division by three, by reciprocal.
    assign n_xh     = r_sh[X_W-1:XL_W];
    assign n_prod_h = PH_W'(n_xh) * PH_W'(RECIP_HI);
    assign n_qh     = n_prod_h[PH_W-1:XL_W];
    assign n_rem    = n_xh - XH_W'(n_qh * XH_W'(3));

    // Low digit, then sign and saturation.
    assign n_y      = {r_rh, r_xl};
    assign n_prod_l = PL_W'(n_y) * PL_W'(RECIP_LO);
    assign n_q      = {r_qh, n_prod_l[RL_SH+XL_W-1:RL_SH]};

    always_comb begin
        if (r_sat) begin
            n_value = r_neg6 ? {1'b1, {(OUT_W-1){1'b0}}} : {1'b0, {(OUT_W-1){1'b1}}};
        end else if (r_neg6) begin
            n_value = -$signed({1'b0, n_q[OUT_W-2:0]});
        end else begin
            n_value = $signed({1'b0, n_q[OUT_W-2:0]});
        end
    end

    always_ff @(posedge i_clk) begin
        r_neg3  <= i_n[N_W-1];
        r_mag   <= n_mag;
        r_neg4  <= r_neg3;
        r_plo   <= n_plo;
        r_phi   <= n_phi;
        r_neg5  <= r_neg4;
        r_sh    <= n_acc[ACC_W-1:RND_SH];
        r_neg6  <= r_neg5;
        r_sat   <= (r_sh >= SAT_LIMIT);
        r_qh    <= n_qh;
        r_rh    <= n_rem[RH_W-1:0];
        r_xl    <= r_sh[XL_W-1:0];
        r_value <= n_value;
    end

    assign o_value = r_value;

endmodule
